@@ design/wpfm_pkg.sv @@
// Shared constants, codes and control types of the windowed pulse frequency meter.
package wpfm_pkg;

  localparam int CHANNELS_DEFAULT  = 3;
  localparam int FRAC_BITS_DEFAULT = 8;

  localparam int FUNC_W   = 2;
  localparam int CHAN_W   = 2;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int WORD_W   = 32;
  localparam int MIN_W    = 20;
  localparam int RATE_W   = 27;
  localparam int NUM_W    = WORD_W + RATE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 27;

  localparam logic [MIN_W-1:0]  MIN_INTERVAL_RESET = MIN_W'(3000);
  localparam logic [RATE_W-1:0] TICK_RATE_RESET    = RATE_W'(1000000);
  localparam logic [WORD_W-1:0] WORD_MAX           = '1;

  localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE    = 1'd1;

  localparam logic [STATUS_W-1:0] ST_SEEDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GLITCH     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ_FRESH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESET_DONE = 3'd5;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic mul;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic read_fresh;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/wpfm_div.sv @@
// Serial restoring divider with a saturating 32-bit quotient of (num << FRAC_BITS) / divisor.
module wpfm_div #(
  parameter int FRAC_BITS = wpfm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [wpfm_pkg::NUM_W-1:0]        num,
  input  logic [wpfm_pkg::WORD_W-1:0]       divisor,
  output logic                              done,
  output logic [wpfm_pkg::WORD_W-1:0]       quot
);

  localparam int W    = wpfm_pkg::WORD_W;
  localparam int NW   = wpfm_pkg::NUM_W + FRAC_BITS;
  localparam int HW   = NW - W;
  localparam int CW   = (HW > W) ? HW : W;
  localparam int STEP_W = $clog2(W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(W - 1);

  logic [NW-1:0]     n_full;
  logic [HW-1:0]     n_hi;
  logic              overflow;
  logic [W:0]        trial;
  logic              q_bit;
  logic [W-1:0]      rem;
  logic [W-1:0]      dvd;
  logic [W-1:0]      div_q;
  logic [STEP_W-1:0] step;
  logic              busy;

  assign n_full   = NW'(num) << FRAC_BITS;
  assign n_hi     = n_full[NW-1:W];
  assign overflow = CW'(n_hi) >= CW'(divisor);
  assign trial    = {rem, dvd[W-1]};
  assign q_bit    = trial >= {1'b0, div_q};
  assign quot     = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        div_q <= divisor;
        step  <= '0;
        if (overflow) begin
          dvd  <= '1;
          done <= 1'b1;
        end else begin
          // Upper part is below the divisor here, so it fits one word.
          rem  <= W'(n_hi);
          dvd  <= n_full[W-1:0];
          busy <= 1'b1;
        end
      end else if (busy) begin
        // One quotient bit a cycle; the dividend word shifts out as quotient shifts in.
        rem  <= q_bit ? W'(trial - {1'b0, div_q}) : trial[W-1:0];
        dvd  <= {dvd[W-2:0], q_bit};
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/wpfm_ctrl.sv @@
// Controller state machine sequencing capture, update, multiply, divide and result hand-off.
module wpfm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wpfm_pkg::dp_status_t dp_status,
  output wpfm_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && dp_status.in_ok) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = dp_status.read_fresh ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (dp_status.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (dp_status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> state == S_EXEC)
    else $error("captured transaction not followed by execute");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    dp_status.div_done |-> state == S_DIV)
    else $error("divider finished outside the divide wait");

  a_div_follows_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> $past(cmd.mul))
    else $error("divider started without a fresh product");

endmodule

@@ design/wpfm_datapath.sv @@
// Datapath: configuration, per-channel window state, product register, divider and result register.
module wpfm_datapath #(
  parameter int CHANNELS  = wpfm_pkg::CHANNELS_DEFAULT,
  parameter int FRAC_BITS = wpfm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [wpfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpfm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [wpfm_pkg::FUNC_W-1:0]         func,
  input  logic [wpfm_pkg::CHAN_W-1:0]         channel,
  input  logic [wpfm_pkg::TIME_W-1:0]         timestamp_ticks,
  input  wpfm_pkg::ctrl_cmd_t                 cmd,
  output wpfm_pkg::dp_status_t                dp_status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wpfm_pkg::STATUS_W-1:0]       status,
  output logic [wpfm_pkg::WORD_W-1:0]         freq_q8,
  output logic [wpfm_pkg::WORD_W-1:0]         window_count,
  output logic [wpfm_pkg::WORD_W-1:0]         window_sum
);

  localparam int W    = wpfm_pkg::WORD_W;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [wpfm_pkg::MIN_W-1:0]  min_interval;
  logic [wpfm_pkg::RATE_W-1:0] tick_rate;

  logic [W-1:0] interval_sum   [CHANNELS];
  logic [W-1:0] interval_count [CHANNELS];
  logic [W-1:0] last_edge_time [CHANNELS];
  logic         seeded         [CHANNELS];

  logic [wpfm_pkg::FUNC_W-1:0] func_q;
  logic [CH_W-1:0]             ch_q;
  logic [W-1:0]                time_q;

  logic [wpfm_pkg::STATUS_W-1:0] res_status;
  logic [W-1:0]                  res_freq;
  logic [W-1:0]                  res_count;
  logic [W-1:0]                  res_sum;
  logic [wpfm_pkg::NUM_W-1:0]    product;

  logic [W-1:0] cur_sum;
  logic [W-1:0] cur_count;
  logic [W-1:0] interval;
  logic         glitch;
  logic [W:0]   sum_wide;
  logic [W:0]   count_wide;
  logic [W-1:0] sum_sat;
  logic [W-1:0] count_sat;
  logic         div_done;
  logic [W-1:0] div_quot;

  assign cur_sum    = interval_sum[ch_q];
  assign cur_count  = interval_count[ch_q];
  assign interval   = time_q - last_edge_time[ch_q];
  assign glitch     = interval < W'(min_interval);
  assign sum_wide   = {1'b0, cur_sum} + {1'b0, interval};
  assign count_wide = {1'b0, cur_count} + (W+1)'(1);
  assign sum_sat    = sum_wide[W] ? wpfm_pkg::WORD_MAX : sum_wide[W-1:0];
  assign count_sat  = count_wide[W] ? wpfm_pkg::WORD_MAX : count_wide[W-1:0];

  assign dp_status.in_ok      = (func != wpfm_pkg::FUNC_NONE) && (32'(channel) < CHANNELS);
  assign dp_status.read_fresh = (func_q == wpfm_pkg::FUNC_READ) && (cur_count != '0)
                                && (cur_sum != '0);
  assign dp_status.div_done   = div_done;
  assign dp_status.out_free   = !out_valid || out_ready;

  wpfm_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .num     (product),
    .divisor (res_sum),
    .done    (div_done),
    .quot    (div_quot)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= wpfm_pkg::MIN_INTERVAL_RESET;
      tick_rate    <= wpfm_pkg::TICK_RATE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wpfm_pkg::REG_MIN_INTERVAL: min_interval <= cfg_data[wpfm_pkg::MIN_W-1:0];
        wpfm_pkg::REG_TICK_RATE:    tick_rate    <= cfg_data[wpfm_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_q <= func;
      ch_q   <= CH_W'(channel);
      time_q <= timestamp_ticks;
    end
  end

  // Per-channel window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        interval_sum[c]   <= '0;
        interval_count[c] <= '0;
        last_edge_time[c] <= '0;
        seeded[c]         <= 1'b0;
      end
    end else if (cmd.exec) begin
      case (func_q)
        wpfm_pkg::FUNC_EDGE: begin
          if (!seeded[ch_q]) begin
            seeded[ch_q]         <= 1'b1;
            last_edge_time[ch_q] <= time_q;
          end else if (!glitch) begin
            interval_sum[ch_q]   <= sum_sat;
            interval_count[ch_q] <= count_sat;
            last_edge_time[ch_q] <= time_q;
          end
        end
        wpfm_pkg::FUNC_READ: begin
          interval_sum[ch_q]   <= '0;
          interval_count[ch_q] <= '0;
        end
        default: begin
          interval_sum[ch_q]   <= '0;
          interval_count[ch_q] <= '0;
          last_edge_time[ch_q] <= '0;
          seeded[ch_q]         <= 1'b0;
        end
      endcase
    end
  end

  // Pending result, product and quotient.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_freq <= '0;
      case (func_q)
        wpfm_pkg::FUNC_EDGE: begin
          if (!seeded[ch_q]) begin
            res_status <= wpfm_pkg::ST_SEEDED;
            res_count  <= cur_count;
            res_sum    <= cur_sum;
          end else if (glitch) begin
            res_status <= wpfm_pkg::ST_GLITCH;
            res_count  <= cur_count;
            res_sum    <= cur_sum;
          end else begin
            res_status <= wpfm_pkg::ST_ACCEPTED;
            res_count  <= count_sat;
            res_sum    <= sum_sat;
          end
        end
        wpfm_pkg::FUNC_READ: begin
          res_status <= dp_status.read_fresh ? wpfm_pkg::ST_READ_FRESH
                                             : wpfm_pkg::ST_READ_EMPTY;
          res_count  <= cur_count;
          res_sum    <= cur_sum;
        end
        default: begin
          res_status <= wpfm_pkg::ST_RESET_DONE;
          res_count  <= '0;
          res_sum    <= '0;
        end
      endcase
    end
    if (cmd.mul) begin
      product <= res_count * tick_rate;
    end
    if (div_done) begin
      res_freq <= div_quot;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      freq_q8      <= res_freq;
      window_count <= res_count;
      window_sum   <= res_sum;
    end
  end

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken transaction");

  a_freq_only_fresh: assert property (@(posedge clk) disable iff (rst)
    (out_valid && freq_q8 != '0) |-> status == wpfm_pkg::ST_READ_FRESH)
    else $error("nonzero frequency on a result that is not a fresh read");

endmodule

@@ design/windowed_pulse_frequency_meter.sv @@
// Top level of the multi-channel windowed pulse frequency meter.
//
// Input channel (in_valid/in_ready): func, channel, timestamp_ticks. func edge
// seeds or extends a channel's window, func read returns the window's average
// frequency in fixed point and clears sum and count (the reference is kept),
// func reset clears the channel. Items with func 3 or an out-of-range channel
// are taken and dropped with no result.
// Output channel (out_valid/out_ready): status, freq_q8, window_count,
// window_sum, one result per kept transaction.
// Config channel (cfg_valid/cfg_ready): cfg_index 0 min_interval_ticks,
// 1 ticks_per_second; always ready, write only while the block is idle.
// An edge or reset passes the execute and done states before its result
// enters the output register; a fresh read also runs a 32x27 multiply and
// the one-bit-a-cycle divider (32 steps); a saturating read skips the steps.
// Throughput: one item at a time; the next item is taken once the controller
// is back in idle, while the previous result may still wait in the output
// register. A stalled receiver holds the result and, once a second result is
// ready, holds the controller until the first transaction completes.
// Reset (rst, synchronous): clears all channels, restores the register
// defaults and drops any pending result.
module windowed_pulse_frequency_meter #(
  parameter int CHANNELS  = wpfm_pkg::CHANNELS_DEFAULT,
  parameter int FRAC_BITS = wpfm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wpfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpfm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wpfm_pkg::FUNC_W-1:0]     func,
  input  logic [wpfm_pkg::CHAN_W-1:0]     channel,
  input  logic [wpfm_pkg::TIME_W-1:0]     timestamp_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wpfm_pkg::STATUS_W-1:0]   status,
  output logic [wpfm_pkg::WORD_W-1:0]     freq_q8,
  output logic [wpfm_pkg::WORD_W-1:0]     window_count,
  output logic [wpfm_pkg::WORD_W-1:0]     window_sum
);

  wpfm_pkg::ctrl_cmd_t  cmd;
  wpfm_pkg::dp_status_t dp_status;

  // Registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  wpfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  wpfm_datapath #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .func            (func),
    .channel         (channel),
    .timestamp_ticks (timestamp_ticks),
    .cmd             (cmd),
    .dp_status       (dp_status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .freq_q8         (freq_q8),
    .window_count    (window_count),
    .window_sum      (window_sum)
  );

endmodule
